// ----- rtl/assert_macros.svh -----
// Assertion helpers; expect clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RMQ_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rmq check failed");

// Next-cycle implication.
`define RMQ_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rmq check failed");

`endif

// ----- rtl/rmq_pkg.sv -----
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int NUM_W  = 17;
    localparam int LANES  = 3;
    localparam int OUT_W  = 16;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;

    typedef enum logic [1:0] {
        CASE_TRACE,
        CASE_M00,
        CASE_M11,
        CASE_M22
    } case_t;

    // sign and magnitude of one off-diagonal numerator
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        case_t             sel;
    } sq_side_t;

    typedef struct packed {
        logic             fault;
        logic [OUT_W-1:0] own;
        case_t            sel;
    } dv_side_t;

endpackage

// ----- rtl/rmq_sqrt.sv -----
module rmq_sqrt #(
    parameter int X_W    = 32,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [X_W-1:0]      in_x,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_vld,
    output logic [X_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int RW = X_W / 2;

    // stage i holds the state after i+1 digits
    logic              vld_reg  [RW];
    logic [X_W-1:0]    x_reg    [RW];
    logic [RW:0]       rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic              vld_src;
        logic [X_W-1:0]    x_src;
        logic [RW:0]       rem_src;
        logic [RW-1:0]     root_src;
        logic [SIDE_W-1:0] side_src;
        logic [RW+2:0]     cur;
        logic [RW+2:0]     trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign vld_src  = in_vld;
            assign x_src    = in_x;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = in_side;
        end
        else begin : g_next
            assign vld_src  = vld_reg[i-1];
            assign x_src    = x_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign root_src = root_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        always_comb
        begin
            cur   = {rem_src, x_src[X_W-1:X_W-2]};
            trial = {1'b0, root_src, 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_src << 2;
                rem_reg[i]  <= ge ? (RW+1)'(cur - trial) : (RW+1)'(cur);
                root_reg[i] <= {root_src[RW-2:0], ge};
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

// ----- rtl/rmq_div.sv -----
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int DEN_W     = 17,
    parameter int SIDE_W    = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_vld,
    input  rmq_pkg::lane_t [rmq_pkg::LANES-1:0]           in_lane,
    input  logic [DEN_W-1:0]                              in_den,
    input  logic [SIDE_W-1:0]                             in_side,
    output logic                                          out_vld,
    output logic [rmq_pkg::LANES-1:0]                     out_neg,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W+FRAC_BITS-1:0] out_quo,
    output logic [SIDE_W-1:0]                             out_side
);

    localparam int DVD_W = rmq_pkg::NUM_W + FRAC_BITS;
    localparam int LN    = rmq_pkg::LANES;

    // one quotient bit per stage; dq shifts dividend out and quotient in
    logic                         vld_reg  [DVD_W];
    logic [DEN_W-1:0]             den_reg  [DVD_W];
    logic [SIDE_W-1:0]            side_reg [DVD_W];
    logic [LN-1:0]                neg_reg  [DVD_W];
    logic [LN-1:0][DEN_W-1:0]     rem_reg  [DVD_W];
    logic [LN-1:0][DVD_W-1:0]     dq_reg   [DVD_W];

    for (genvar i = 0; i < DVD_W; i++) begin : g_stage
        logic                     vld_src;
        logic [DEN_W-1:0]         den_src;
        logic [SIDE_W-1:0]        side_src;
        logic [LN-1:0]            neg_src;
        logic [LN-1:0][DEN_W-1:0] rem_src;
        logic [LN-1:0][DVD_W-1:0] dq_src;
        logic [LN-1:0][DEN_W-1:0] rem_nxt;
        logic [LN-1:0][DVD_W-1:0] dq_nxt;

        if (i == 0) begin : g_first
            assign vld_src  = in_vld;
            assign den_src  = in_den;
            assign side_src = in_side;
            for (genvar l = 0; l < LN; l++) begin : g_ld
                assign neg_src[l] = in_lane[l].neg;
                assign rem_src[l] = '0;
                assign dq_src[l]  = {in_lane[l].mag, {FRAC_BITS{1'b0}}};
            end
        end
        else begin : g_next
            assign vld_src  = vld_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
            assign neg_src  = neg_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign dq_src   = dq_reg[i-1];
        end

        for (genvar l = 0; l < LN; l++) begin : g_lane
            logic [DEN_W:0] t;
            logic           ge;
            always_comb
            begin
                t          = {rem_src[l], dq_src[l][DVD_W-1]};
                ge         = (t >= {1'b0, den_src});
                rem_nxt[l] = ge ? DEN_W'(t - {1'b0, den_src}) : DEN_W'(t);
                dq_nxt[l]  = {dq_src[l][DVD_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i]  <= den_src;
                side_reg[i] <= side_src;
                neg_reg[i]  <= neg_src;
                rem_reg[i]  <= rem_nxt;
                dq_reg[i]   <= dq_nxt;
            end
        end
    end

    assign out_vld  = vld_reg[DVD_W-1];
    assign out_neg  = neg_reg[DVD_W-1];
    assign out_quo  = dq_reg[DVD_W-1];
    assign out_side = side_reg[DVD_W-1];

endmodule

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion converter.
// s_* stream: one 3x3 matrix per transaction, nine signed Q2.14 elements.
// m_* stream: one quaternion per transaction, the branch taken and a flag
// for a zero divisor. APB port: trace_threshold at address 0, reset 16;
// write it only while the pipeline is empty.
// Pipeline: the stage 1 register, the square-root stages, the divider stages
// and the output register. ROOT_W is the square-root digit count (16 at
// FRAC_BITS = 14) and DVD_W is 17 + FRAC_BITS quotient bits. The square
// root yields one digit per stage and the three dividers one bit each.
// Throughput: one transaction per cycle while the receiver takes results.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the threshold register.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20, elem_21, elem_22
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]  m_tdata,
    // case_taken, div_fault
    output logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RAD_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int X_RAW   = RAD_W + FRAC_BITS;
    localparam int X_W     = X_RAW + (X_RAW % 2);
    localparam int ROOT_W  = X_W / 2;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int DVD_W   = rmq_pkg::NUM_W + FRAC_BITS;
    localparam int HALF_W  = (ROOT_W > rmq_pkg::OUT_W) ? ROOT_W : rmq_pkg::OUT_W;
    localparam int THR_W   = 15;
    localparam int NW      = rmq_pkg::NUM_W;
    localparam int OW      = rmq_pkg::OUT_W;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] thr_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-THR_W){1'b0}}, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(16);
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic out_vld_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: branch, radicand, numerators ----------------
    logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [RAD_W:0] one_s, t_s, rad_s;
    logic signed [NW-1:0] n21m12, n02m20, n10m01, n10p01, n02p20, n21p12;
    logic signed [NW-1:0] num [rmq_pkg::LANES];
    rmq_pkg::case_t       sel;
    rmq_pkg::sq_side_t    sq_side;
    logic [RAD_W-1:0]     rad_u;

    assign a00 = s_tdata[15:0];
    assign a01 = s_tdata[31:16];
    assign a02 = s_tdata[47:32];
    assign a10 = s_tdata[63:48];
    assign a11 = s_tdata[79:64];
    assign a12 = s_tdata[95:80];
    assign a20 = s_tdata[111:96];
    assign a21 = s_tdata[127:112];
    assign a22 = s_tdata[143:128];

    always_comb
    begin
        one_s  = signed'((RAD_W+1)'(1) << FRAC_BITS);
        t_s    = one_s + (RAD_W+1)'(a00) + (RAD_W+1)'(a11) + (RAD_W+1)'(a22);
        n21m12 = NW'(a21) - NW'(a12);
        n02m20 = NW'(a02) - NW'(a20);
        n10m01 = NW'(a10) - NW'(a01);
        n10p01 = NW'(a10) + NW'(a01);
        n02p20 = NW'(a02) + NW'(a20);
        n21p12 = NW'(a21) + NW'(a12);

        if (t_s > signed'({{(RAD_W+1-THR_W){1'b0}}, thr_reg}))
        begin
            sel = rmq_pkg::CASE_TRACE;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            sel = rmq_pkg::CASE_M00;
        end
        else if (a11 > a22)
        begin
            sel = rmq_pkg::CASE_M11;
        end
        else
        begin
            sel = rmq_pkg::CASE_M22;
        end

        // lanes hold the divided components in the order they are placed later
        unique case (sel)
            rmq_pkg::CASE_TRACE:
            begin
                rad_s  = t_s;
                num[0] = n21m12;
                num[1] = n02m20;
                num[2] = n10m01;
            end
            rmq_pkg::CASE_M00:
            begin
                rad_s  = one_s + (RAD_W+1)'(a00) - (RAD_W+1)'(a11) - (RAD_W+1)'(a22);
                num[0] = n10p01;
                num[1] = n02p20;
                num[2] = n21m12;
            end
            rmq_pkg::CASE_M11:
            begin
                rad_s  = one_s + (RAD_W+1)'(a11) - (RAD_W+1)'(a00) - (RAD_W+1)'(a22);
                num[0] = n10p01;
                num[1] = n21p12;
                num[2] = n02m20;
            end
            default:
            begin
                rad_s  = one_s + (RAD_W+1)'(a22) - (RAD_W+1)'(a00) - (RAD_W+1)'(a11);
                num[0] = n02p20;
                num[1] = n21p12;
                num[2] = n10m01;
            end
        endcase

        // clamp a negative radicand to zero
        rad_u = rad_s[RAD_W] ? '0 : rad_s[RAD_W-1:0];

        sq_side.sel = sel;
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            sq_side.lane[l].neg = num[l][NW-1];
            sq_side.lane[l].mag = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
        end
    end

    logic              st1_vld_reg;
    logic [X_W-1:0]    st1_x_reg;
    rmq_pkg::sq_side_t st1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            st1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_x_reg    <= X_W'({rad_u, {FRAC_BITS{1'b0}}});
            st1_side_reg <= sq_side;
        end
    end

    // ---------------- square root ----------------
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    rmq_pkg::sq_side_t sq_out_side;

    rmq_sqrt #(
        .X_W    (X_W),
        .SIDE_W ($bits(rmq_pkg::sq_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (st1_vld_reg),
        .in_x     (st1_x_reg),
        .in_side  (st1_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_out_side)
    );

    // own component is S/4 = floor(root/2)
    logic [HALF_W-1:0] half_w;
    rmq_pkg::dv_side_t dv_in_side;
    logic [DEN_W-1:0]  den;

    always_comb
    begin
        half_w           = HALF_W'(sq_root >> 1);
        dv_in_side.sel   = sq_out_side.sel;
        dv_in_side.fault = (sq_root == '0);
        dv_in_side.own   = (half_w > HALF_W'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX
                                                                : half_w[OW-1:0];
        den              = {sq_root, 1'b0};
    end

    // ---------------- dividers ----------------
    logic                                dv_vld;
    logic [rmq_pkg::LANES-1:0]           dv_neg;
    logic [rmq_pkg::LANES-1:0][DVD_W-1:0] dv_quo;
    rmq_pkg::dv_side_t                   dv_side;

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .DEN_W     (DEN_W),
        .SIDE_W    ($bits(rmq_pkg::dv_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sq_vld),
        .in_lane  (sq_out_side.lane),
        .in_den   (den),
        .in_side  (dv_in_side),
        .out_vld  (dv_vld),
        .out_neg  (dv_neg),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // ---------------- saturate, place, output register ----------------
    logic [OW-1:0] lane_sat [rmq_pkg::LANES];
    logic [OW-1:0] w_next, x_next, y_next, z_next;

    always_comb
    begin
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            if (dv_side.fault)
            begin
                lane_sat[l] = '0;
            end
            else if (dv_neg[l])
            begin
                lane_sat[l] = (dv_quo[l] > DVD_W'(rmq_pkg::OUT_MIN)) ? rmq_pkg::OUT_MIN
                                                                     : OW'(-dv_quo[l]);
            end
            else
            begin
                lane_sat[l] = (dv_quo[l] > DVD_W'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX
                                                                     : dv_quo[l][OW-1:0];
            end
        end

        unique case (dv_side.sel)
            rmq_pkg::CASE_TRACE:
            begin
                w_next = dv_side.own;
                x_next = lane_sat[0];
                y_next = lane_sat[1];
                z_next = lane_sat[2];
            end
            rmq_pkg::CASE_M00:
            begin
                x_next = dv_side.own;
                y_next = lane_sat[0];
                z_next = lane_sat[1];
                w_next = lane_sat[2];
            end
            rmq_pkg::CASE_M11:
            begin
                x_next = lane_sat[0];
                y_next = dv_side.own;
                z_next = lane_sat[1];
                w_next = lane_sat[2];
            end
            default:
            begin
                x_next = lane_sat[0];
                y_next = lane_sat[1];
                z_next = dv_side.own;
                w_next = lane_sat[2];
            end
        endcase
    end

    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {z_next, y_next, x_next, w_next};
            out_user_reg <= {dv_side.fault, dv_side.sel};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- checks ----------------
    `RMQ_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[2], m_tdata == 64'd0)
    `RMQ_ASSERT_IMP(a_trace_no_fault, m_tvalid && (m_tuser[1:0] == rmq_pkg::CASE_TRACE), !m_tuser[2])
    `RMQ_ASSERT_IMP(a_trace_w_pos, m_tvalid && (m_tuser[1:0] == rmq_pkg::CASE_TRACE), !m_tdata[15])
    `RMQ_ASSERT_NXT(a_cfg_write, cfg_wr, thr_reg == $past(pwdata[THR_W-1:0]))

endmodule

// ----- tb/rmq_checker.sv -----
`timescale 1ns / 100ps

module rmq_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic [14:0]  threshold,
    output int           fail_count,
    output int           pending
);

    localparam int FB = 14;

    typedef struct {
        logic [15:0]     w;
        logic [15:0]     x;
        logic [15:0]     y;
        logic [15:0]     z;
        rmq_pkg::case_t  sel;
        logic            fault;
    } quat_t;

    quat_t quat_q[$];

    function automatic longint floor_sqrt(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd4000000000;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // SV division of signed longints truncates toward zero
    function automatic longint over_s(longint n, longint s);
        if (s == 0)
            return 0;
        return (n * (longint'(1) << FB)) / s;
    endfunction

    function automatic quat_t convert(logic [143:0] d, logic [14:0] thr);
        longint m[9];
        longint one;
        longint t;
        longint rad;
        longint s;
        longint w;
        longint x;
        longint y;
        longint z;
        quat_t q;
        for (int i = 0; i < 9; i++)
            m[i] = longint'($signed(d[16*i +: 16]));
        one = longint'(1) << FB;
        t = one + m[0] + m[4] + m[8];
        if (t > longint'(thr))
        begin
            q.sel = rmq_pkg::CASE_TRACE;
            rad = t;
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            q.sel = rmq_pkg::CASE_M00;
            rad = one + m[0] - m[4] - m[8];
        end
        else if (m[4] > m[8])
        begin
            q.sel = rmq_pkg::CASE_M11;
            rad = one + m[4] - m[0] - m[8];
        end
        else
        begin
            q.sel = rmq_pkg::CASE_M22;
            rad = one + m[8] - m[0] - m[4];
        end
        if (rad < 0)
            rad = 0;
        s = 2 * floor_sqrt(rad << FB);
        case (q.sel)
            rmq_pkg::CASE_TRACE:
            begin
                w = s / 4;
                x = over_s(m[7] - m[5], s);
                y = over_s(m[2] - m[6], s);
                z = over_s(m[3] - m[1], s);
            end
            rmq_pkg::CASE_M00:
            begin
                x = s / 4;
                y = over_s(m[3] + m[1], s);
                z = over_s(m[2] + m[6], s);
                w = over_s(m[7] - m[5], s);
            end
            rmq_pkg::CASE_M11:
            begin
                x = over_s(m[3] + m[1], s);
                y = s / 4;
                z = over_s(m[7] + m[5], s);
                w = over_s(m[2] - m[6], s);
            end
            default:
            begin
                x = over_s(m[2] + m[6], s);
                y = over_s(m[7] + m[5], s);
                z = s / 4;
                w = over_s(m[3] - m[1], s);
            end
        endcase
        q.w = clip16(w);
        q.x = clip16(x);
        q.y = clip16(y);
        q.z = clip16(z);
        q.fault = (s == 0);
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                quat_q.push_back(convert(s_tdata, threshold));
            if (m_tvalid && m_tready)
            begin
                if (quat_q.size() == 0)
                    report_mismatch("unexpected transaction", m_tdata[15:0], 16'h0);
                else
                begin
                    e = quat_q.pop_front();
                    if (m_tdata[15:0] != e.w)
                        report_mismatch("quat_w", m_tdata[15:0], e.w);
                    if (m_tdata[31:16] != e.x)
                        report_mismatch("quat_x", m_tdata[31:16], e.x);
                    if (m_tdata[47:32] != e.y)
                        report_mismatch("quat_y", m_tdata[47:32], e.y);
                    if (m_tdata[63:48] != e.z)
                        report_mismatch("quat_z", m_tdata[63:48], e.z);
                    if (m_tuser[1:0] != e.sel)
                        report_mismatch("case_taken", m_tuser[1:0], e.sel);
                    if (m_tuser[2] != e.fault)
                        report_mismatch("div_fault", m_tuser[2], e.fault);
                end
            end
        end
        pending = quat_q.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = 49;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20, elem_21, elem_22
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // quat_w, quat_x, quat_y, quat_z
    logic [63:0]  m_tdata;
    // case_taken, div_fault
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic [14:0]  threshold;
    int           fail_count;
    int           pending;
    bit           hold_off;
    bit           bursty_sink;

    rotation_matrix_to_quaternion i_dut (.*);

    rmq_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .threshold(threshold),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, with a long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = bursty_sink ? $urandom_range(0, 5) : 0;
            if (gap == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        threshold = data[14:0];
    endtask

    task automatic send_matrix(logic [143:0] d, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [143:0] pack_matrix(int a[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++)
            d[16*i +: 16] = a[i][15:0];
        return d;
    endfunction

    // random elements; kinds 1 to 3 bias the diagonal toward the branch wanted
    function automatic logic [143:0] shaped_matrix(int kind);
        int a[9];
        for (int i = 0; i < 9; i++)
            a[i] = $urandom_range(0, 32767) - 16384;
        case (kind)
            0: ;
            1:
            begin
                a[0] = $urandom_range(0, 16384);
                a[4] = -$urandom_range(8000, 16384);
                a[8] = -$urandom_range(8000, 16384);
            end
            2:
            begin
                a[4] = $urandom_range(0, 16384);
                a[0] = -$urandom_range(8000, 16384);
                a[8] = -$urandom_range(8000, 16384);
            end
            3:
            begin
                a[8] = $urandom_range(0, 16384);
                a[0] = -$urandom_range(8000, 16384);
                a[4] = -$urandom_range(8000, 16384);
            end
            4:
            begin
                // trace term near the threshold, ties likely
                a[0] = -$urandom_range(5450, 5470);
                a[4] = $urandom_range(0, 1) ? a[0] : -$urandom_range(5450, 5470);
                a[8] = -16384 - a[0] - a[4] + $urandom_range(0, 40) - 20;
            end
            default:
                for (int i = 0; i < 9; i++)
                    a[i] = $urandom_range(0, 65535) - 32768;
        endcase
        return pack_matrix(a);
    endfunction

    initial
    begin
        int a[9];
        logic [14:0] thr_list[4];
        thr_list = '{15'd0, 15'd16384, 15'd300, 15'd16};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_THRESHOLD;
        pwdata = '0;
        threshold = 15'd16;
        hold_off = 1'b0;
        bursty_sink = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, extremes, ties, each branch
        a = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-32768, 32767, 32767, -32768, -32768, 32767, -32768, 32767, -32768};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-16384, 5, 7, -3, -16384, 9, 1, -2, 16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-32768, 100, 0, 0, 32767, 0, 0, 0, -32768};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 0};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-16400, 3, 4, 5, -16400, 6, 7, 8, -16400};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, -16384};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, -16368};
        send_matrix(pack_matrix(a), 1'b0);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, -16367};
        send_matrix(pack_matrix(a), 1'b0);
        drain();

        // random phases across thresholds, extremes among them
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write(ADDR_THRESHOLD, {17'd0, thr_list[ph]});
            bursty_sink = (ph != 2);
            for (int n = 0; n < 380; n++)
            begin
                if (ph == 1 && n == 100)
                    hold_off = 1'b1;
                send_matrix(shaped_matrix($urandom_range(0, 5)), ph != 3 || n > 150);
            end
            drain();
        end
        apb_write(ADDR_THRESHOLD, 32'h0000_7FFF);
        for (int n = 0; n < 20; n++)
            send_matrix(shaped_matrix($urandom_range(0, 5)), 1'b1);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
